/* design/tsp_pkg.sv */
// shared types, constants and the sequencer program for the touch slider block
// no dependencies; used by touch_slider_position_top
package tsp_pkg;

	localparam int COUNT_W = 16;
	localparam int DELTA_W = 15;
	localparam int SUM_W   = 16;
	localparam int POS_W   = 6;
	localparam int PC_W    = 4;

	localparam logic [COUNT_W-1:0] THRESH_RST = 16'd100;

	localparam logic OP_SCAN = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [1:0] {
		REG_BASE0 = 2'd0,
		REG_BASE1 = 2'd1,
		REG_THR0  = 2'd2,
		REG_THR1  = 2'd3
	} reg_addr_t;

	typedef struct packed {
		logic               opcode;
		logic [COUNT_W-1:0] scan_count;
	} in_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             recomputed;
	} out_t;

	// micro operations of the datapath
	typedef enum logic [2:0] {
		U_WAIT,
		U_FRESH,
		U_LOAD0,
		U_DIV,
		U_LOAD1,
		U_FINAL,
		U_ZERO,
		U_OUT
	} uop_t;

	// jump conditions, a false condition falls through to the next step
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_READ,
		C_NO_FRESH,
		C_NO_HIT,
		C_DIV_BUSY,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		uop_t            op;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ucode_t;

	localparam logic [PC_W-1:0] PC_WAIT  = 4'd0;
	localparam logic [PC_W-1:0] PC_FRESH = 4'd1;
	localparam logic [PC_W-1:0] PC_LOAD0 = 4'd2;
	localparam logic [PC_W-1:0] PC_DIV0  = 4'd3;
	localparam logic [PC_W-1:0] PC_LOAD1 = 4'd4;
	localparam logic [PC_W-1:0] PC_DIV1  = 4'd5;
	localparam logic [PC_W-1:0] PC_FINAL = 4'd6;
	localparam logic [PC_W-1:0] PC_ZERO  = 4'd7;
	localparam logic [PC_W-1:0] PC_OUT   = 4'd8;
	localparam logic [PC_W-1:0] PC_BACK  = 4'd9;

	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		unique case (pc)
			PC_WAIT:  w = '{op: U_WAIT,  cond: C_NO_READ,  target: PC_WAIT};
			PC_FRESH: w = '{op: U_FRESH, cond: C_NO_FRESH, target: PC_OUT};
			PC_LOAD0: w = '{op: U_LOAD0, cond: C_NO_HIT,   target: PC_ZERO};
			PC_DIV0:  w = '{op: U_DIV,   cond: C_DIV_BUSY, target: PC_DIV0};
			PC_LOAD1: w = '{op: U_LOAD1, cond: C_NEVER,    target: PC_WAIT};
			PC_DIV1:  w = '{op: U_DIV,   cond: C_DIV_BUSY, target: PC_DIV1};
			PC_FINAL: w = '{op: U_FINAL, cond: C_ALWAYS,   target: PC_OUT};
			PC_ZERO:  w = '{op: U_ZERO,  cond: C_NEVER,    target: PC_WAIT};
			PC_OUT:   w = '{op: U_OUT,   cond: C_OUT_BUSY, target: PC_OUT};
			PC_BACK:  w = '{op: U_WAIT,  cond: C_ALWAYS,   target: PC_WAIT};
			default:  w = '{op: U_WAIT,  cond: C_ALWAYS,   target: PC_WAIT};
		endcase
		return w;
	endfunction

endpackage

/* design/touch_slider_position_top.sv */
// top level of the two-electrode capacitive slider position block
// depends on tsp_pkg for payload types, register map and the sequencer program

// Two-electrode slider. In a scan transfer (opcode 0) the scan count
// minus that electrode's baseline, clamped at zero, becomes the electrode's
// delta, and the electrodes alternate, the second one marking the pair fresh.
// A read transfer (opcode 1) gives one result. With fresh data and either
// delta above its threshold, the position is (L - d0*L/sum + d1*L/sum)/2 with
// L = SLIDER_MM; with fresh data and no touch it is 0; without fresh data the
// held position is repeated and recomputed is 0. A microcoded sequencer runs
// the read: a 10-step program in a constant table drives two multiplications, one
// shared restoring divider (one quotient bit a cycle) and the final average.
// A fresh touched read runs both divisions before its result is loaded; a
// read without fresh data or an untouched fresh read skips them. in_ready is
// high only while the sequencer waits, the result sits in an output register
// so a new transfer is taken while it waits for out_ready. Registers at byte
// addresses 0, 4, 8, 12: baselines of electrode 0 and 1, thresholds of
// electrode 0 and 1 (reset 100).
module touch_slider_position_top #(
	parameter int SLIDER_MM = 40
) (
	input  logic               clk,
	input  logic               arst_n,
	// item input
	input  logic               in_valid,
	output logic               in_ready,
	input  tsp_pkg::in_t       in_data,
	// result output
	output logic               out_valid,
	input  logic               out_ready,
	output tsp_pkg::out_t      out_data,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	// quotient width, numerator width and division step counter width
	localparam int MW = $clog2(SLIDER_MM + 1);
	localparam int NW = tsp_pkg::DELTA_W + MW;
	localparam int CW = $clog2(NW);

	localparam logic [CW-1:0] LAST_STEP = CW'(NW - 1);

	// configuration registers
	logic [tsp_pkg::COUNT_W-1:0] base0_q, base1_q, thr0_q, thr1_q;

	// slider state
	logic [tsp_pkg::DELTA_W-1:0] d0_q, d1_q;
	logic                        cur_q;
	logic                        fresh_q;
	logic [tsp_pkg::POS_W-1:0]   held_q;
	logic                        rcmp_q;

	// sequencer and datapath
	logic [tsp_pkg::PC_W-1:0]   pc_q, pc_next;
	tsp_pkg::ucode_t            uw;
	logic [NW-1:0]              num_q;
	logic [tsp_pkg::SUM_W-1:0]  rem_q, sum_q;
	logic [CW-1:0]              cnt_q;
	logic [MW-1:0]              p0_q;

	// output register
	logic          out_valid_q;
	tsp_pkg::out_t out_q;

	// combinational helpers
	logic                        in_xfer, cfg_wr, hit, jump, out_free, out_load;
	logic [tsp_pkg::COUNT_W-1:0] base_sel, diff;
	logic [tsp_pkg::DELTA_W-1:0] delta;
	logic [tsp_pkg::SUM_W:0]     trial;
	logic                        qbit;
	logic [tsp_pkg::SUM_W-1:0]   rem_next;
	logic [MW:0]                 avg_sum;
	logic [MW-1:0]               avg;

	// microcode fetch
	assign uw = tsp_pkg::ucode_rom(pc_q);

	// only the wait step decodes a read, so input is taken there alone
	assign in_ready = (pc_q == tsp_pkg::PC_WAIT);
	assign in_xfer  = in_valid && in_ready;

	// apb write strobe, no wait states
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (tsp_pkg::reg_addr_t'(paddr[3:2]))
			tsp_pkg::REG_BASE0: prdata = 32'(base0_q);
			tsp_pkg::REG_BASE1: prdata = 32'(base1_q);
			tsp_pkg::REG_THR0:  prdata = 32'(thr0_q);
			tsp_pkg::REG_THR1:  prdata = 32'(thr1_q);
			default:            prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base0_q <= '0;
			base1_q <= '0;
			thr0_q  <= tsp_pkg::THRESH_RST;
			thr1_q  <= tsp_pkg::THRESH_RST;
		end else if (cfg_wr) begin
			unique case (tsp_pkg::reg_addr_t'(paddr[3:2]))
				tsp_pkg::REG_BASE0: base0_q <= pwdata[tsp_pkg::COUNT_W-1:0];
				tsp_pkg::REG_BASE1: base1_q <= pwdata[tsp_pkg::COUNT_W-1:0];
				tsp_pkg::REG_THR0:  thr0_q  <= pwdata[tsp_pkg::COUNT_W-1:0];
				tsp_pkg::REG_THR1:  thr1_q  <= pwdata[tsp_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// scan delta: 16-bit wrap, negative clamps to zero
	assign base_sel = cur_q ? base1_q : base0_q;
	assign diff     = in_data.scan_count - base_sel;
	assign delta    = diff[tsp_pkg::COUNT_W-1] ? '0 : diff[tsp_pkg::DELTA_W-1:0];

	// touch test on the held deltas
	assign hit = (tsp_pkg::COUNT_W'(d0_q) > thr0_q) || (tsp_pkg::COUNT_W'(d1_q) > thr1_q);

	// one restoring division step, quotient bits shift into num_q
	assign trial    = {rem_q, num_q[NW-1]};
	assign qbit     = (trial >= {1'b0, sum_q});
	assign rem_next = qbit ? tsp_pkg::SUM_W'(trial - {1'b0, sum_q})
	                       : trial[tsp_pkg::SUM_W-1:0];

	// average of the two ratio positions, p0 <= L so no underflow
	assign avg_sum = (MW+1)'(SLIDER_MM) - {1'b0, p0_q} + {1'b0, num_q[MW-1:0]};
	assign avg     = avg_sum[MW:1];

	// output slot
	assign out_free = !out_valid_q || out_ready;
	assign out_load = (uw.op == tsp_pkg::U_OUT) && out_free;

	// jump condition and next step
	always_comb begin
		unique case (uw.cond)
			tsp_pkg::C_NEVER:    jump = 1'b0;
			tsp_pkg::C_ALWAYS:   jump = 1'b1;
			tsp_pkg::C_NO_READ:  jump = !(in_xfer && (in_data.opcode == tsp_pkg::OP_READ));
			tsp_pkg::C_NO_FRESH: jump = !fresh_q;
			tsp_pkg::C_NO_HIT:   jump = !hit;
			tsp_pkg::C_DIV_BUSY: jump = (cnt_q != LAST_STEP);
			tsp_pkg::C_OUT_BUSY: jump = !out_free;
			default:             jump = 1'b1;
		endcase
		pc_next = jump ? uw.target : pc_q + 1'b1;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= tsp_pkg::PC_WAIT;
			d0_q        <= '0;
			d1_q        <= '0;
			cur_q       <= 1'b0;
			fresh_q     <= 1'b1;
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_next;
			// scan transfer updates the current electrode
			if (in_xfer && (in_data.opcode == tsp_pkg::OP_SCAN)) begin
				cur_q <= !cur_q;
				if (cur_q) begin
					d1_q    <= delta;
					fresh_q <= 1'b1;
				end else begin
					d0_q <= delta;
				end
			end
			if (uw.op == tsp_pkg::U_FINAL) begin
				held_q  <= tsp_pkg::POS_W'(avg);
				fresh_q <= 1'b0;
			end
			if (uw.op == tsp_pkg::U_ZERO) begin
				held_q  <= '0;
				fresh_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (uw.op)
			tsp_pkg::U_FRESH: rcmp_q <= fresh_q;
			tsp_pkg::U_LOAD0: begin
				sum_q <= tsp_pkg::SUM_W'(d0_q) + tsp_pkg::SUM_W'(d1_q);
				num_q <= NW'(d0_q) * NW'(SLIDER_MM);
				rem_q <= '0;
				cnt_q <= '0;
			end
			tsp_pkg::U_DIV: begin
				num_q <= {num_q[NW-2:0], qbit};
				rem_q <= rem_next;
				cnt_q <= cnt_q + 1'b1;
			end
			tsp_pkg::U_LOAD1: begin
				p0_q  <= num_q[MW-1:0];
				num_q <= NW'(d1_q) * NW'(SLIDER_MM);
				rem_q <= '0;
				cnt_q <= '0;
			end
			tsp_pkg::U_OUT: begin
				if (out_free) begin
					out_q.position   <= held_q;
					out_q.recomputed <= rcmp_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef NO_ASSERTIONS
	// second electrode scan marks the pair fresh
	a_scan_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && (in_data.opcode == tsp_pkg::OP_SCAN) && cur_q) |=> fresh_q)
		else $error("second scan did not mark data fresh");

	// a loaded result carries the held position
	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_q.position == held_q))
		else $error("result position differs from held position");

	// positions never pass the slider length
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (8'(out_q.position) <= 8'(SLIDER_MM)))
		else $error("position beyond slider length");

	// partial remainder stays below the divisor
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(uw.op == tsp_pkg::U_DIV) |-> (rem_q < sum_q))
		else $error("division remainder out of range");
`endif

endmodule
